// File: hdl/bsp_pkg.sv
// shared types and constants for the b-spline basis evaluator
package bsp_pkg;

  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 33;

  localparam int unsigned BASIS_W = 31;
  localparam logic [BASIS_W-1:0] BASIS_ONE = 31'h4000_0000;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage

// File: hdl/bsp_ram.sv
// generic simple dual-port ram with registered read
module bsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bsp_div.sv
// iterative restoring unsigned divider, one quotient bit per cycle
module bsp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bsp_pkg::div_req_t req,
  output bsp_pkg::div_rsp_t rsp
);
  import bsp_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              take;

  assign take    = req.start && !busy_r;
  assign rem_sh  = {rem_r, quo_r[DIV_NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      // borrow clear means the shifted remainder covers the divisor
      if (!rem_sub[DIV_DW]) begin
        rem_r <= rem_sub[DIV_DW-1:0];
        quo_r <= {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DIV_DW-1:0];
        quo_r <= {quo_r[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: hdl/bspline_basis_eval_top.sv
// top level: knot table ram, cox-de boor sequencer and output register
//
// Input channel in_*: mode 0 writes in_knot_value to knot slot in_index,
// mode 1 evaluates basis in_index of order in_order at in_position.
// Every transfer gives exactly one result on the out_* channel.
// The block takes one item at a time; in_stall is high while an item is
// being worked on. A write goes straight to the finish state, where in_stall
// stays high, and from there into the output register. An evaluate walks the
// recursion one node at a time: per node four knot reads through the
// single read port of the table, then up to two quotients on the shared
// divider. Order k uses k(k+1)/2 basis nodes plus up to four derivative
// nodes, so order four uses fourteen nodes, order two four and order one one.
// Invalid index or order takes the same path as a write, with status 1.
// The finished result sits in an output register; the next item is taken
// while it waits. With out_stall high the result holds, and the block
// waits before presenting another one.
// Reset clears control state only; knot slots read back garbage until
// written, no clearing pass is done.
module bspline_basis_eval_top #(
  parameter int NUM_KNOTS = 32,
  parameter int MAX_ORDER = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [4:0]         in_index,
  input  logic [2:0]         in_order,
  input  logic signed [31:0] in_knot_value,
  input  logic signed [31:0] in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_basis_value,
  output logic signed [31:0] out_first_derivative,
  output logic signed [31:0] out_second_derivative,
  output logic [1:0]         out_status
);
  import bsp_pkg::*;

  localparam int AW    = $clog2(NUM_KNOTS);
  localparam int CW    = AW + 6;
  localparam int QD    = (MAX_ORDER < 3) ? 3 : MAX_ORDER;
  localparam int QCW   = $clog2(QD + 1);
  localparam int A_W   = 38;
  localparam int RES_W = 60;
  localparam int TQ_W  = DIV_NW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NEXT = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_RD3  = 4'd5;
  localparam logic [3:0] S_RD4  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_WAIT = 4'd10;
  localparam logic [3:0] S_COMB = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  localparam logic [2:0] PH_L1  = 3'd0;
  localparam logic [2:0] PH_LVL = 3'd1;
  localparam logic [2:0] PH_DK  = 3'd2;
  localparam logic [2:0] PH_DA  = 3'd3;
  localparam logic [2:0] PH_DB  = 3'd4;
  localparam logic [2:0] PH_D2  = 3'd5;

  localparam logic [1:0] OP_BASIS = 2'd0;
  localparam logic [1:0] OP_D1    = 2'd1;
  localparam logic [1:0] OP_D2    = 2'd2;

  localparam logic signed [RES_W-1:0] SMAX = RES_W'(64'sd2147483647);
  localparam logic signed [RES_W-1:0] SMIN = RES_W'(-64'sd2147483648);
  localparam logic signed [TQ_W:0]    ONE_X = (TQ_W+1)'(64'sd1073741824);

  // control
  logic [3:0]     state_r;
  logic [2:0]     ph_r;
  logic [2:0]     k_r;
  logic [2:0]     j_r;
  logic [2:0]     m_r;
  logic [QCW-1:0] cnt_r;
  logic           out_valid_r;
  logic           tsel_r;

  // payload
  logic [AW-1:0]            i_r;
  logic signed [31:0]       t_r;
  logic [1:0]               op_r;
  logic [2:0]               nj_r;
  logic [2:0]               nm_r;
  logic signed [A_W-1:0]    a0_r, a1_r;
  logic signed [31:0]       kj_r, kj1_r, kjm1_r, kjm_r;
  logic [DIV_NW-1:0]        num_r;
  logic [DIV_DW-1:0]        den_r;
  logic                     neg_r;
  logic                     skip_r;
  logic signed [TQ_W-1:0]   tq0_r, tq1_r;
  logic signed [RES_W-1:0]  res_r;
  logic [BASIS_W-1:0]       q_r [QD];
  logic [BASIS_W-1:0]       lb_r, rb_r, n0_r, n1_r, n2_r;
  logic signed [RES_W-1:0]  d1_r, d2_r, da_r, db_r;
  logic                     ev_r;
  logic [1:0]               st_r;
  logic [30:0]              obv_r;
  logic signed [31:0]       od1_r, od2_r;
  logic [1:0]               ost_r;

  logic              accept;
  logic              eval_bad;
  logic              wr_ok;
  logic              ram_we;
  logic [AW-1:0]     raddr;
  logic [31:0]       rdata;
  logic [3:0]        roff;
  logic signed [31:0] rd_s;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign eval_bad = (in_order == 3'd0) || ({1'b0, in_order} > 4'(MAX_ORDER)) ||
                    ((CW'(in_index) + CW'(in_order)) > CW'(NUM_KNOTS - 1));
  assign wr_ok    = CW'(in_index) < CW'(NUM_KNOTS);
  assign ram_we   = accept && (in_mode == MODE_WRITE) && wr_ok;

  always_comb begin
    unique case (state_r)
      S_RD1:   roff = {1'b0, nj_r} + 4'd1;
      S_RD2:   roff = {1'b0, nj_r} + {1'b0, nm_r} - 4'd1;
      S_RD3:   roff = {1'b0, nj_r} + {1'b0, nm_r};
      default: roff = {1'b0, nj_r};
    endcase
  end

  assign raddr = i_r + AW'(roff);
  assign rd_s  = $signed(rdata);

  bsp_ram #(.WIDTH(32), .DEPTH(NUM_KNOTS)) u_knots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_index)),
    .wdata (in_knot_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // term datapath
  logic signed [32:0]       tk0, tk1, d0s, d1s, dsel;
  logic [32:0]              dmag;
  logic signed [A_W-1:0]    asel;
  logic [A_W-1:0]           amag;
  logic [30:0]              mul_a;
  logic [32:0]              mul_b;
  logic [63:0]              prod;
  logic [DIV_NW-1:0]        num_c;
  logic                     neg_c;
  logic                     skip_c;
  logic                     zero_b;
  logic signed [TQ_W-1:0]   quo_s;
  logic signed [TQ_W:0]     sum_b;
  logic signed [TQ_W:0]     diff_d;
  logic signed [TQ_W+4:0]   scaled;

  assign tk0  = {t_r[31], t_r} - {kj_r[31], kj_r};
  assign tk1  = {kjm_r[31], kjm_r} - {t_r[31], t_r};
  assign d0s  = {kjm1_r[31], kjm1_r} - {kj_r[31], kj_r};
  assign d1s  = {kjm_r[31], kjm_r} - {kj1_r[31], kj1_r};
  assign dsel = tsel_r ? d1s : d0s;
  assign dmag = dsel[32] ? 33'(-dsel) : 33'(dsel);
  assign asel = tsel_r ? a1_r : a0_r;
  assign amag = asel[A_W-1] ? A_W'(-asel) : A_W'(asel);
  assign mul_a = asel[30:0];
  assign mul_b = tsel_r ? tk1 : tk0;
  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign zero_b = (t_r >= kjm_r) || (t_r < kj_r);

  always_comb begin
    unique case (op_r)
      OP_BASIS: begin
        num_c  = prod;
        neg_c  = 1'b0;
        skip_c = (asel == '0);
      end
      OP_D1: begin
        num_c  = DIV_NW'(amag) << 2;
        neg_c  = dsel[32];
        skip_c = (dsel == '0);
      end
      default: begin
        num_c  = DIV_NW'(amag) << 16;
        neg_c  = asel[A_W-1] ^ dsel[32];
        skip_c = (dsel == '0);
      end
    endcase
  end

  assign quo_s  = neg_r ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
  assign sum_b  = (TQ_W+1)'(tq0_r) + (TQ_W+1)'(tq1_r);
  assign diff_d = (TQ_W+1)'(tq0_r) - (TQ_W+1)'(tq1_r);
  assign scaled = diff_d * $signed({1'b0, 3'(nm_r - 3'd1)});

  assign div_req.start = (state_r == S_DIV) && !skip_r;
  assign div_req.num   = num_r;
  assign div_req.den   = den_r;

  bsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic ovf(input logic signed [RES_W-1:0] v);
    ovf = (v > SMAX) || (v < SMIN);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [RES_W-1:0] v);
    logic [31:0] r;
    if (v > SMAX) begin
      r = 32'h7fff_ffff;
    end else if (v < SMIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    sat32 = r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_L1;
      k_r         <= '0;
      j_r         <= '0;
      m_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      tsel_r      <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_mode == MODE_WRITE || eval_bad) begin
              ev_r    <= 1'b0;
              st_r    <= (in_mode == MODE_WRITE && wr_ok) ? ST_OK : ST_ERR;
              state_r <= S_FIN;
            end else begin
              ev_r    <= 1'b1;
              i_r     <= AW'(in_index);
              k_r     <= in_order;
              t_r     <= in_position;
              ph_r    <= PH_L1;
              j_r     <= '0;
              cnt_r   <= '0;
              d1_r    <= '0;
              d2_r    <= '0;
              state_r <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          unique case (ph_r)
            PH_L1: begin
              if (j_r != k_r) begin
                op_r <= OP_BASIS; nj_r <= j_r; nm_r <= 3'd1;
                a0_r <= '0; a1_r <= '0;
                state_r <= S_RD0;
              end else if (k_r == 3'd1) begin
                state_r <= S_FIN;
              end else begin
                ph_r <= PH_LVL;
                m_r  <= 3'd2;
                j_r  <= '0;
              end
            end
            PH_LVL: begin
              if (j_r <= k_r - m_r) begin
                // queue head holds the previous level at the start of a level
                if (j_r == 3'd0 && m_r == k_r) begin
                  lb_r <= q_r[0];
                  rb_r <= q_r[1];
                end
                if (j_r == 3'd0 && m_r == k_r - 3'd1) begin
                  n0_r <= q_r[0];
                  n1_r <= q_r[1];
                  n2_r <= q_r[2];
                end
                op_r <= OP_BASIS; nj_r <= j_r; nm_r <= m_r;
                a0_r <= A_W'(q_r[0]); a1_r <= A_W'(q_r[1]);
                state_r <= S_RD0;
              end else begin
                // drop the leftover of the previous level
                for (int x = 0; x < QD - 1; x++) begin
                  q_r[x] <= q_r[x+1];
                end
                cnt_r <= cnt_r - 1'b1;
                j_r   <= '0;
                if (m_r == k_r) begin
                  ph_r <= PH_DK;
                end else begin
                  m_r <= m_r + 3'd1;
                end
              end
            end
            PH_DK: begin
              op_r <= OP_D1; nj_r <= 3'd0; nm_r <= k_r;
              a0_r <= A_W'(lb_r); a1_r <= A_W'(rb_r);
              state_r <= S_RD0;
            end
            PH_DA: begin
              op_r <= OP_D1; nj_r <= 3'd0; nm_r <= k_r - 3'd1;
              a0_r <= A_W'(n0_r); a1_r <= A_W'(n1_r);
              state_r <= S_RD0;
            end
            PH_DB: begin
              op_r <= OP_D1; nj_r <= 3'd1; nm_r <= k_r - 3'd1;
              a0_r <= A_W'(n1_r); a1_r <= A_W'(n2_r);
              state_r <= S_RD0;
            end
            default: begin
              op_r <= OP_D2; nj_r <= 3'd0; nm_r <= k_r;
              a0_r <= A_W'(da_r); a1_r <= A_W'(db_r);
              state_r <= S_RD0;
            end
          endcase
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin kj_r   <= rd_s; state_r <= S_RD2; end
        S_RD2: begin kj1_r  <= rd_s; state_r <= S_RD3; end
        S_RD3: begin kjm1_r <= rd_s; state_r <= S_RD4; end
        S_RD4: begin kjm_r  <= rd_s; state_r <= S_CHK; end
        S_CHK: begin
          tsel_r <= 1'b0;
          if (op_r == OP_BASIS && zero_b) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else if (op_r == OP_BASIS && nm_r == 3'd1) begin
            res_r   <= RES_W'(BASIS_ONE);
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          num_r   <= num_c;
          den_r   <= dmag;
          neg_r   <= neg_c;
          skip_r  <= skip_c;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (skip_r) begin
            if (tsel_r) begin
              tq1_r   <= '0;
              state_r <= S_COMB;
            end else begin
              tq0_r   <= '0;
              tsel_r  <= 1'b1;
              state_r <= S_MUL;
            end
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            if (tsel_r) begin
              tq1_r   <= quo_s;
              state_r <= S_COMB;
            end else begin
              tq0_r   <= quo_s;
              tsel_r  <= 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_COMB: begin
          if (op_r == OP_BASIS) begin
            res_r <= (sum_b > ONE_X) ? RES_W'(BASIS_ONE) : RES_W'(sum_b);
          end else begin
            res_r <= RES_W'(scaled);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          unique case (ph_r)
            PH_L1: begin
              for (int x = 0; x < QD; x++) begin
                if (x == int'(cnt_r)) q_r[x] <= res_r[BASIS_W-1:0];
              end
              cnt_r   <= cnt_r + 1'b1;
              j_r     <= j_r + 3'd1;
              state_r <= S_NEXT;
            end
            PH_LVL: begin
              // pop the head and append the new value, count unchanged
              for (int x = 0; x < QD; x++) begin
                if (x == int'(cnt_r) - 1) begin
                  q_r[x] <= res_r[BASIS_W-1:0];
                end else if (x < QD - 1) begin
                  q_r[x] <= q_r[x+1];
                end
              end
              j_r     <= j_r + 3'd1;
              state_r <= S_NEXT;
            end
            PH_DK: begin
              d1_r <= res_r;
              if (k_r >= 3'd3) begin
                ph_r    <= PH_DA;
                state_r <= S_NEXT;
              end else begin
                state_r <= S_FIN;
              end
            end
            PH_DA: begin
              da_r    <= res_r;
              ph_r    <= PH_DB;
              state_r <= S_NEXT;
            end
            PH_DB: begin
              db_r    <= res_r;
              ph_r    <= PH_D2;
              state_r <= S_NEXT;
            end
            default: begin
              d2_r    <= res_r;
              state_r <= S_FIN;
            end
          endcase
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            if (ev_r) begin
              obv_r <= q_r[0];
              od1_r <= sat32(d1_r);
              od2_r <= sat32(d2_r);
              ost_r <= (ovf(d1_r) || ovf(d2_r)) ? ST_SAT : ST_OK;
            end else begin
              obv_r <= '0;
              od1_r <= '0;
              od2_r <= '0;
              ost_r <= st_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_basis_value       = obv_r;
  assign out_first_derivative  = od1_r;
  assign out_second_derivative = od2_r;
  assign out_status            = ost_r;

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT))
    else $error("quotient arrived outside the wait state");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QD))
    else $error("basis queue overflow");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("knot write during evaluation");

  a_basis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_basis_value <= BASIS_ONE) && (out_status != 2'd3))
    else $error("result out of range");
`endif

endmodule

// File: tb/tb_bspline_basis_eval_top.sv
// testbench for the b-spline basis evaluator: directed table, then random items
module tb_bspline_basis_eval_top;
  import bsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKNOT     = 32;
  localparam int NRANDOM   = 580;
  localparam int CYC_LIMIT = 4_000_000;
  localparam longint unsigned UNIT = 64'd1 << 30;

  typedef struct {
    logic [30:0]        basis;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic [1:0]         status;
  } eval_res_t;

  typedef struct {
    logic               mode;
    logic [4:0]         index;
    logic [2:0]         order;
    logic signed [31:0] knot;
    logic signed [31:0] pos;
    bit                 typed;
    eval_res_t          res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = MODE_WRITE;
  logic [4:0]         in_index = '0;
  logic [2:0]         in_order = '0;
  logic signed [31:0] in_knot_value = '0;
  logic signed [31:0] in_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [30:0]        out_basis_value;
  logic signed [31:0] out_first_derivative;
  logic signed [31:0] out_second_derivative;
  logic [1:0]         out_status;

  longint    knots[NKNOT];
  bit        knot_set[NKNOT];
  eval_res_t pending_res[$];
  stim_row_t dir_rows[$];
  int        n_errors = 0;
  int        cycle_cnt = 0;
  int        items_sent = 0;
  bit        calm = 1'b0;

  bspline_basis_eval_top #(.NUM_KNOTS(NKNOT), .MAX_ORDER(4)) DUT (.*);

  always #1 clk = ~clk;

  // cox-de boor basis value, unsigned q1.30
  function automatic longint unsigned basis_q30(int i, int k, longint t);
    longint unsigned lft, rgt, acc, dv;
    acc = 0;
    if (t >= knots[i+k] || t < knots[i]) return 0;
    if (k == 1) return UNIT;
    lft = basis_q30(i, k - 1, t);
    rgt = basis_q30(i + 1, k - 1, t);
    if (lft != 0) begin
      dv = longint'(knots[i+k-1] - knots[i]);
      acc += lft * longint'(t - knots[i]) / dv;
    end
    if (rgt != 0) begin
      dv = longint'(knots[i+k] - knots[i+1]);
      acc += rgt * longint'(knots[i+k] - t) / dv;
    end
    return (acc > UNIT) ? UNIT : acc;
  endfunction

  function automatic longint slope_q16(int i, int k, longint t);
    longint d1, d0, r;
    r = 0;
    if (k <= 1) return 0;
    d1 = knots[i+k] - knots[i+1];
    d0 = knots[i+k-1] - knots[i];
    if (d1 != 0) r -= longint'(basis_q30(i + 1, k - 1, t) * 4) / d1;
    if (d0 != 0) r += longint'(basis_q30(i, k - 1, t) * 4) / d0;
    return longint'(k - 1) * r;
  endfunction

  function automatic longint curve_q16(int i, int k, longint t);
    longint d1, d0, r;
    r = 0;
    if (k <= 2) return 0;
    d1 = knots[i+k] - knots[i+1];
    d0 = knots[i+k-1] - knots[i];
    if (d1 != 0) r -= slope_q16(i + 1, k - 1, t) * 65536 / d1;
    if (d0 != 0) r += slope_q16(i, k - 1, t) * 65536 / d0;
    return longint'(k - 1) * r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // updates the knot copy on writes and returns the expected result
  function automatic eval_res_t predict_eval(stim_row_t s);
    eval_res_t r;
    bit        hit;
    longint    t;
    hit = 1'b0;
    r = '{basis: '0, d1: '0, d2: '0, status: ST_OK};
    if (s.mode == MODE_WRITE) begin
      knots[s.index] = longint'(s.knot);
      knot_set[s.index] = 1'b1;
      return r;
    end
    if (s.order == 0 || s.order > 4 || int'(s.index) + int'(s.order) > NKNOT - 1) begin
      r.status = ST_ERR;
      return r;
    end
    t = longint'(s.pos);
    r.basis = 31'(basis_q30(s.index, s.order, t));
    r.d1 = clamp32(slope_q16(s.index, s.order, t), hit);
    r.d2 = clamp32(curve_q16(s.index, s.order, t), hit);
    r.status = hit ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic add_row(logic m, int idx, int ord, logic signed [31:0] kv,
                         logic signed [31:0] p, bit typed, logic [30:0] b,
                         logic [1:0] st);
    stim_row_t s;
    s.mode = m;
    s.index = 5'(idx);
    s.order = 3'(ord);
    s.knot = kv;
    s.pos = p;
    s.typed = typed;
    s.res = '{basis: b, d1: '0, d2: '0, status: st};
    dir_rows.push_back(s);
  endtask

  task automatic send_item(stim_row_t s);
    eval_res_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_mode = s.mode;
    in_index = s.index;
    in_order = s.order;
    in_knot_value = s.knot;
    in_position = s.pos;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = predict_eval(s);
    if (s.typed) r = s.res;
    pending_res.push_back(r);
    items_sent++;
  endtask

  // picks a random write or evaluate; a valid evaluate with an unwritten knot writes that slot
  function automatic stim_row_t rand_item();
    stim_row_t s;
    int        sel, gap;
    longint    lo, hi;
    s = '{mode: MODE_EVAL, index: 5'($urandom), order: 0, knot: $urandom, pos: $urandom,
          typed: 1'b0, res: '{basis: '0, d1: '0, d2: '0, status: ST_OK}};
    sel = $urandom_range(0, 15);
    if (sel == 1) s.order = 3'($urandom_range(5, 7));
    else if (sel >= 2) s.order = 3'((sel < 5) ? 1 : (sel < 9) ? 2 : (sel < 13) ? 3 : 4);
    if ($urandom_range(0, 3) == 0) s.mode = MODE_WRITE;
    else if (s.order != 0 && s.order <= 4 && int'(s.index) + int'(s.order) <= NKNOT - 1)
      for (int j = 0; j <= s.order; j++)
        if (!knot_set[s.index + j]) begin
          s.mode = MODE_WRITE;
          s.index = 5'(int'(s.index) + j);
          break;
        end
    if (s.mode == MODE_WRITE) begin
      case ($urandom_range(0, 5))
        0: s.knot = $urandom;
        1: s.knot = int'(s.index) <<< 16;
        2: s.knot = (s.index != 0 && knot_set[s.index-1])
                      ? 32'(knots[s.index-1] + $urandom_range(0, 3)) : int'(s.index) <<< 16;
        default: s.knot = (int'(s.index) <<< 16) + $urandom_range(0, 65535) - 32768;
      endcase
    end else if (s.order <= 4 && int'(s.index) + int'(s.order) <= NKNOT - 1) begin
      lo = knots[s.index];
      hi = knots[s.index + s.order];
      gap = $urandom_range(0, 5);
      if (gap == 1) s.pos = 32'(knots[s.index + 1]);
      else if (gap >= 2 && hi > lo) s.pos = 32'(lo + longint'($urandom) % (hi - lo));
    end
    return s;
  endfunction

  always @(negedge clk)
    out_stall <= !calm && $urandom_range(0, 99) < 13;

  // result checker
  always @(posedge clk) begin
    eval_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        $error("result transfer with nothing expected");
        n_errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_basis_value !== e.basis) begin
          $error("basis_value: expected %0d, got %0d", e.basis, out_basis_value);
          n_errors++;
        end
        if (out_first_derivative !== e.d1) begin
          $error("first_derivative: expected %0d, got %0d", e.d1, out_first_derivative);
          n_errors++;
        end
        if (out_second_derivative !== e.d2) begin
          $error("second_derivative: expected %0d, got %0d", e.d2, out_second_derivative);
          n_errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int settle;
    // uniform knots 0..6 in slots 0..6, then the extremes in slots 7 and 8
    for (int j = 0; j < 7; j++) add_row(MODE_WRITE, j, 0, j <<< 16, 0, 1, 0, ST_OK);
    add_row(MODE_WRITE, 7, 0, 32'sh8000_0000, 0, 1, 0, ST_OK);
    add_row(MODE_WRITE, 8, 0, 32'sh7fff_ffff, 0, 1, 0, ST_OK);
    add_row(MODE_EVAL, 0, 1, 0, 32'sh0000_8000, 1, 31'h4000_0000, ST_OK);
    add_row(MODE_EVAL, 2, 1, 0, 32'sh0002_0000, 1, 31'h4000_0000, ST_OK);
    add_row(MODE_EVAL, 0, 2, 0, 32'sh0001_4000, 0, 0, ST_OK);
    add_row(MODE_EVAL, 0, 3, 0, 32'sh0001_8000, 0, 0, ST_OK);
    add_row(MODE_EVAL, 1, 4, 0, 32'sh0003_2000, 0, 0, ST_OK);
    add_row(MODE_EVAL, 0, 4, 0, 32'sh8000_0000, 1, 0, ST_OK);
    add_row(MODE_EVAL, 0, 4, 0, 32'sh7fff_ffff, 1, 0, ST_OK);
    add_row(MODE_EVAL, 4, 4, 0, 32'sh0006_8000, 0, 0, ST_OK);
    add_row(MODE_EVAL, 0, 0, 0, 0, 1, 0, ST_ERR);
    add_row(MODE_EVAL, 0, 7, 0, 0, 1, 0, ST_ERR);
    add_row(MODE_EVAL, 2, 5, 0, 0, 1, 0, ST_ERR);
    add_row(MODE_EVAL, 31, 1, 0, 0, 1, 0, ST_ERR);
    add_row(MODE_EVAL, 28, 4, 0, 0, 1, 0, ST_ERR);
    // zero-length spans: slot 9 duplicates slot 6, slot 10 one lsb above
    add_row(MODE_WRITE, 9, 0, 32'sh0006_0000, 0, 1, 0, ST_OK);
    add_row(MODE_WRITE, 10, 0, 32'sh0006_0001, 0, 1, 0, ST_OK);
    add_row(MODE_WRITE, 11, 0, 32'sh0007_0000, 0, 1, 0, ST_OK);
    add_row(MODE_EVAL, 8, 3, 0, 32'sh0006_0000, 0, 0, ST_OK);
    add_row(MODE_EVAL, 7, 4, 0, 32'sh0006_0000, 0, 0, ST_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[n]) send_item(dir_rows[n]);
    for (int n = 0; n < NRANDOM; n++) begin
      calm = (n >= 250 && n < 350);
      if (n == 400) begin
        // hold off until the block has drained
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
      end
      send_item(rand_item());
    end
    @(negedge clk);
    in_valid = 1'b0;
    calm = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 50) begin
      @(posedge clk);
      settle++;
    end
    if (n_errors == 0 && pending_res.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: bspline_basis_eval_top.f
hdl/bsp_pkg.sv
hdl/bsp_ram.sv
hdl/bsp_div.sv
hdl/bspline_basis_eval_top.sv
tb/tb_bspline_basis_eval_top.sv
